// ===== design/rwlt_pkg.sv =====
// ----------------------------------------------------------------------------
// rwlt_pkg
// Shared types, codes and helpers for the replica write lifecycle tracker.
// ----------------------------------------------------------------------------
package rwlt_pkg;

  localparam int unsigned Hosts     = 8;
  localparam int unsigned LockWidth = 16;
  localparam int unsigned QDepth    = 2;

  typedef logic [Hosts-1:0]     hmask_t;
  typedef logic [LockWidth-1:0] lock_t;

  typedef enum logic [3:0] {
    K_START    = 4'd0,
    K_RESTORE  = 4'd1,
    K_WRITE    = 4'd2,
    K_BELATED  = 4'd3,
    K_FL_REQ   = 4'd4,
    K_FL_OK    = 4'd5,
    K_FL_FAIL  = 4'd6,
    K_ER_REQ   = 4'd7,
    K_ER_OK    = 4'd8,
    K_ER_FAIL  = 4'd9,
    K_HOSTS    = 4'd10,
    K_LOCK     = 4'd11,
    K_UNLOCK   = 4'd12,
    K_QUERY    = 4'd13,
    K_BAD14    = 4'd14,
    K_BAD15    = 4'd15
  } kind_e;

  typedef enum logic [2:0] {
    ST_PENDING    = 3'd0,
    ST_INCOMPLETE = 3'd1,
    ST_WRITTEN    = 3'd2,
    ST_FLUSHING   = 3'd3,
    ST_FLUSHED    = 3'd4,
    ST_DISCARDED  = 3'd5,
    ST_ERASED     = 3'd6,
    ST_UNUSED     = 3'd7
  } phase_e;

  localparam logic [4:0] QReqFlush   = 5'd1;
  localparam logic [4:0] QRegClone   = 5'd2;
  localparam logic [4:0] QRegErase   = 5'd4;
  localparam logic [4:0] QUnregErase = 5'd8;
  localparam logic [4:0] QFlushed    = 5'd16;

  localparam logic [3:0] BTotalAdd = 4'd1;
  localparam logic [3:0] BTotalRel = 4'd2;
  localparam logic [3:0] BLockAdd  = 4'd4;
  localparam logic [3:0] BLockRel  = 4'd8;

  localparam logic [3:0] SrcNone = 4'd8;
  localparam int unsigned CntW = $clog2(Hosts + 1);

  // Decoded request as it travels from the front to the back part.
  typedef struct packed {
    kind_e          kind;
    logic           host_ok;
    hmask_t         hb;
    logic [2:0]     host;
    hmask_t         a;
    hmask_t         b;
    hmask_t         c;
  } req_t;

  typedef struct packed {
    logic       status;
    phase_e     phase;
    logic [3:0] src;
    logic [4:0] qact;
    hmask_t     finished;
    logic [3:0] bact;
    hmask_t     bhosts;
    logic       qreached;
    hmask_t     read_hosts;
    logic       read_buf;
    hmask_t     inflight;
    hmask_t     erase_needed;
  } res_t;

  typedef struct packed {
    phase_e phase;
    hmask_t desired;
    hmask_t disabled;
    hmask_t wreq;
    hmask_t wok;
    hmask_t wans;
    hmask_t freq;
    hmask_t fok;
    hmask_t ereq;
    hmask_t eok;
    hmask_t eearly;
    lock_t  lock;
  } rec_t;

  function automatic logic [CntW-1:0] popc(input hmask_t m);
    logic [CntW-1:0] n;
    n = '0;
    for (int i = 0; i < Hosts; i++) n = n + CntW'(m[i]);
    return n;
  endfunction

  function automatic logic [3:0] lowest(input hmask_t m);
    logic [3:0] r;
    r = SrcNone;
    for (int i = Hosts - 1; i >= 0; i--) if (m[i]) r = 4'(i);
    return r;
  endfunction

endpackage

// ===== design/rwlt_front.sv =====
// ----------------------------------------------------------------------------
// rwlt_front
// Accepts events, masks them to the host count, decodes the host bit and
// places requests into a short queue toward the back part.
// ----------------------------------------------------------------------------
module rwlt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [3:0]            kind_i,
  input  logic [2:0]            host_i,
  input  logic [7:0]            mask_a_i,
  input  logic [7:0]            mask_b_i,
  input  logic [7:0]            mask_c_i,
  output logic                  req_valid_o,
  output rwlt_pkg::req_t        req_o,
  input  logic                  req_take_i
);

  localparam int unsigned PtrW = $clog2(rwlt_pkg::QDepth);

  rwlt_pkg::req_t      mem_q [rwlt_pkg::QDepth];
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]       cnt_q, cnt_d;
  rwlt_pkg::req_t      dec;
  logic                wr, rd;

  always_comb begin
    dec.kind    = rwlt_pkg::kind_e'(kind_i);
    dec.host    = host_i;
    dec.host_ok = 32'(host_i) < rwlt_pkg::Hosts;
    dec.hb      = '0;
    if (dec.host_ok) dec.hb[host_i] = 1'b1;
    dec.a = rwlt_pkg::hmask_t'(mask_a_i);
    dec.b = rwlt_pkg::hmask_t'(mask_b_i);
    dec.c = rwlt_pkg::hmask_t'(mask_c_i);
  end

  assign full_o      = cnt_q == (PtrW+1)'(rwlt_pkg::QDepth);
  assign req_valid_o = cnt_q != '0;
  assign req_o       = mem_q[rptr_q];
  assign wr          = push_i && !full_o;
  assign rd          = req_take_i && req_valid_o;

  always_comb begin
    wptr_d = wr ? wptr_q + PtrW'(1) : wptr_q;
    rptr_d = rd ? rptr_q + PtrW'(1) : rptr_q;
    cnt_d  = cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== design/rwlt_back.sv =====
// ----------------------------------------------------------------------------
// rwlt_back
// Holds the record, applies one request per cycle while the output queue has room,
// and registers the result into a two-entry output queue.
// ----------------------------------------------------------------------------
module rwlt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [3:0]            quorum_i,
  input  logic                  req_valid_i,
  input  rwlt_pkg::req_t        req_i,
  output logic                  req_take_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output rwlt_pkg::res_t        res_o
);

  rwlt_pkg::rec_t s_q, s_d, n;
  rwlt_pkg::res_t r;
  rwlt_pkg::res_t oq_q [2];
  logic           rp_q, wp_q;
  logic [1:0]     oc_q;
  logic           bad;
  logic [3:0]     src;
  logic [4:0]     qact;
  logic [3:0]     bact;
  rwlt_pkg::hmask_t bhosts, fin, hb, a, b, c;
  logic           qreached;

  function automatic logic can_erase(input rwlt_pkg::rec_t x);
    return x.phase == rwlt_pkg::ST_FLUSHED || x.phase == rwlt_pkg::ST_DISCARDED;
  endfunction

  function automatic logic can_forget(input rwlt_pkg::rec_t x);
    return ((x.wreq & ~(x.wans | x.disabled)) == '0) &&
           ((x.wreq & ~x.disabled & ~x.eok) == '0);
  endfunction

  function automatic logic inv_ok(input rwlt_pkg::rec_t x, input logic [3:0] q);
    logic ok;
    logic qw;
    rwlt_pkg::hmask_t infl;
    infl = x.freq & ~x.fok;
    qw   = 32'(rwlt_pkg::popc(x.wok)) >= 32'(q);
    ok = ((x.wok & ~x.wreq) == '0) && ((x.wans & ~x.wreq) == '0) &&
         ((x.fok & ~x.disabled & ~x.freq) == '0) &&
         ((x.freq & ~x.disabled & ~x.desired) == '0) &&
         ((x.eok & ~x.ereq) == '0) && ((x.ereq & ~x.wreq) == '0) &&
         ((x.eearly & ~x.ereq) == '0) && ((x.eearly & x.eok) == '0);
    unique case (x.phase)
      rwlt_pkg::ST_PENDING: ok = ok && x.wreq == '0 && x.wok == '0 &&
        x.freq == '0 && x.fok == '0 && x.ereq == '0 && x.eok == '0;
      rwlt_pkg::ST_INCOMPLETE: ok = ok && x.freq == '0 && x.fok == '0 &&
        x.ereq == '0 && x.eok == '0 && !qw;
      rwlt_pkg::ST_WRITTEN: ok = ok && qw && x.freq == '0 && x.fok == '0 &&
        x.ereq == '0 && x.eok == '0;
      rwlt_pkg::ST_FLUSHING: ok = ok && qw && x.ereq == '0 && x.eok == '0;
      rwlt_pkg::ST_FLUSHED: ok = ok && infl == '0 &&
        32'(rwlt_pkg::popc(x.fok)) >= 32'(q);
      rwlt_pkg::ST_DISCARDED: ok = ok && infl == '0 && x.lock == '0;
      default: ok = ok && infl == '0 && can_forget(x) && x.lock == '0;
    endcase
    return ok;
  endfunction

  // Transition legality; staying in the same state is also legal.
  function automatic logic trans_ok(input rwlt_pkg::phase_e p,
                                    input rwlt_pkg::phase_e ns);
    logic ok;
    unique case (ns)
      rwlt_pkg::ST_INCOMPLETE: ok = p == rwlt_pkg::ST_PENDING;
      rwlt_pkg::ST_WRITTEN:    ok = p == rwlt_pkg::ST_PENDING ||
                                    p == rwlt_pkg::ST_INCOMPLETE;
      rwlt_pkg::ST_FLUSHING:   ok = p == rwlt_pkg::ST_WRITTEN;
      rwlt_pkg::ST_FLUSHED:    ok = p == rwlt_pkg::ST_FLUSHING;
      rwlt_pkg::ST_DISCARDED:  ok = p == rwlt_pkg::ST_PENDING;
      rwlt_pkg::ST_ERASED:     ok = p == rwlt_pkg::ST_FLUSHED ||
                                    p == rwlt_pkg::ST_DISCARDED;
      default:                 ok = 1'b0;
    endcase
    return ok || p == ns;
  endfunction

  logic out_full;
  assign out_full   = oc_q == 2'd2;
  assign req_take_o = !out_full;
  assign empty_o    = oc_q == 2'd0;
  assign res_o      = oq_q[rp_q];

  always_comb begin
    logic do_set;
    rwlt_pkg::phase_e ns;
    rwlt_pkg::hmask_t ans, done, infl, dropped, live, cand_m;
    logic [3:0] cand;
    n = s_q; bad = 1'b0; src = rwlt_pkg::SrcNone; qact = '0; bact = '0;
    bhosts = '0; fin = '0; qreached = 1'b0;
    hb = req_i.hb; a = req_i.a; b = req_i.b; c = req_i.c;
    ans = '0; done = '0; infl = '0; dropped = '0; live = '0; cand_m = '0;
    cand = rwlt_pkg::SrcNone; do_set = 1'b0; ns = s_q.phase;

    case (req_i.kind)
      rwlt_pkg::K_RESTORE, rwlt_pkg::K_FL_REQ, rwlt_pkg::K_FL_OK,
      rwlt_pkg::K_FL_FAIL, rwlt_pkg::K_ER_REQ, rwlt_pkg::K_ER_OK,
      rwlt_pkg::K_ER_FAIL: if (!req_i.host_ok) bad = 1'b1;
      default: ;
    endcase

    if (!bad) begin
      case (req_i.kind)
        rwlt_pkg::K_START: begin
          n = '0;
          n.desired = a; n.disabled = b;
        end
        rwlt_pkg::K_RESTORE: begin
          if (!(s_q.phase == rwlt_pkg::ST_PENDING || s_q.phase == rwlt_pkg::ST_INCOMPLETE
                || s_q.phase == rwlt_pkg::ST_WRITTEN) || (s_q.wreq & hb) != '0 ||
              (s_q.wok & hb) != '0) bad = 1'b1;
          else begin
            n.wreq = s_q.wreq | hb; n.wok = s_q.wok | hb; n.wans = s_q.wans | hb;
            bact = bact | rwlt_pkg::BTotalAdd; bhosts = hb;
            if (32'(rwlt_pkg::popc(n.wok)) >= 32'(quorum_i)) begin
              qreached = s_q.phase != rwlt_pkg::ST_WRITTEN;
              ns = rwlt_pkg::ST_WRITTEN; qact = qact | rwlt_pkg::QReqFlush;
            end else begin
              ns = rwlt_pkg::ST_INCOMPLETE; qact = qact | rwlt_pkg::QRegClone;
            end
            // Staying in the same state skips the record checks.
            if (!trans_ok(n.phase, ns)) bad = 1'b1;
            else if (ns != n.phase) begin
              n.phase = ns; if (!inv_ok(n, quorum_i)) bad = 1'b1;
            end
          end
        end
        rwlt_pkg::K_WRITE: begin
          if (s_q.phase != rwlt_pkg::ST_PENDING || s_q.wok != '0) bad = 1'b1;
          else begin
            n.wreq = a; n.wok = b; n.wans = c;
            bact = bact | rwlt_pkg::BTotalAdd; bhosts = a;
            if (32'(rwlt_pkg::popc(b)) >= 32'(quorum_i)) begin
              n.phase = rwlt_pkg::ST_WRITTEN; qact = qact | rwlt_pkg::QReqFlush;
              qreached = 1'b1;
              if (!inv_ok(n, quorum_i)) bad = 1'b1;
            end else begin
              n.phase = rwlt_pkg::ST_DISCARDED;
              if (!inv_ok(n, quorum_i)) bad = 1'b1;
              if (n.lock == '0 && can_forget(n)) begin
                n.phase = rwlt_pkg::ST_ERASED;
                if (!inv_ok(n, quorum_i)) bad = 1'b1;
                bact = bact | rwlt_pkg::BTotalRel; bhosts = n.wreq;
              end
              if (n.lock == '0 && can_erase(n) &&
                  (n.wreq & ~n.disabled & ~n.ereq) != '0)
                qact = qact | rwlt_pkg::QRegErase;
            end
          end
        end
        rwlt_pkg::K_BELATED: begin
          ans = a | b;
          if ((a & b) != '0 || (ans & ~s_q.wreq) != '0 ||
              s_q.phase == rwlt_pkg::ST_ERASED) bad = 1'b1;
          else begin
            n.wok = s_q.wok | a; n.wans = s_q.wans | ans;
            done = ans & s_q.eok;
            infl = ans & s_q.ereq & ~s_q.eok;
            n.eearly = s_q.eearly | infl;
            n.ereq = s_q.ereq & ~done; n.eok = s_q.eok & ~done;
            do_set = 1'b1;
          end
        end
        rwlt_pkg::K_FL_REQ: begin
          if (!(s_q.phase == rwlt_pkg::ST_WRITTEN || s_q.phase == rwlt_pkg::ST_FLUSHING))
            bad = 1'b1;
          else if ((s_q.desired & ~s_q.disabled & hb) != '0 && (s_q.freq & hb) == '0)
          begin
            if ((s_q.wok & hb) != '0) cand = {1'b0, req_i.host};
            else begin
              cand_m = s_q.wok & ~s_q.disabled;
              cand = rwlt_pkg::lowest(cand_m);
              if (cand == rwlt_pkg::SrcNone) cand = rwlt_pkg::lowest(s_q.wok);
            end
            if (cand == rwlt_pkg::SrcNone) bad = 1'b1;
            else begin
              n.phase = rwlt_pkg::ST_FLUSHING;
              n.freq = s_q.freq | hb;
              if (s_q.phase != rwlt_pkg::ST_FLUSHING && !inv_ok(n, quorum_i)) bad = 1'b1;
              src = cand;
            end
          end
        end
        rwlt_pkg::K_FL_OK, rwlt_pkg::K_FL_FAIL: begin
          if (s_q.phase != rwlt_pkg::ST_FLUSHING || (s_q.freq & hb) == '0 ||
              (s_q.fok & hb) != '0) bad = 1'b1;
          else begin
            fin = hb;
            if (req_i.kind == rwlt_pkg::K_FL_OK) n.fok = s_q.fok | hb;
            else begin
              n.freq = s_q.freq & ~hb; qact = qact | rwlt_pkg::QReqFlush;
            end
          end
        end
        rwlt_pkg::K_ER_REQ: begin
          if (!can_erase(s_q) || (s_q.wreq & hb) == '0 || (s_q.ereq & hb) != '0 ||
              (s_q.eok & hb) != '0 || s_q.lock != '0) bad = 1'b1;
          else n.ereq = s_q.ereq | hb;
        end
        rwlt_pkg::K_ER_OK: begin
          if (!can_erase(s_q) || (s_q.ereq & hb) == '0 || (s_q.eok & hb) != '0 ||
              s_q.lock != '0) bad = 1'b1;
          else if ((s_q.eearly & hb) != '0) begin
            n.eearly = s_q.eearly & ~hb; n.ereq = s_q.ereq & ~hb;
            if ((n.wreq & ~n.disabled & ~n.ereq) != '0) qact = qact | rwlt_pkg::QRegErase;
          end else begin
            n.eok = s_q.eok | hb;
            if (can_forget(n)) begin
              n.phase = rwlt_pkg::ST_ERASED;
              if (!inv_ok(n, quorum_i)) bad = 1'b1;
              bact = bact | rwlt_pkg::BTotalRel; bhosts = n.wreq;
            end
          end
        end
        rwlt_pkg::K_ER_FAIL: begin
          if (!(can_erase(s_q) || s_q.phase == rwlt_pkg::ST_ERASED) ||
              (s_q.eok & hb) != '0 || s_q.lock != '0) bad = 1'b1;
          else if (s_q.phase == rwlt_pkg::ST_ERASED) begin
            if ((s_q.disabled & hb) == '0) bad = 1'b1;
          end else begin
            n.eearly = s_q.eearly & ~hb; n.ereq = s_q.ereq & ~hb;
            if ((n.wreq & ~n.disabled & ~n.ereq) != '0) qact = qact | rwlt_pkg::QRegErase;
          end
        end
        rwlt_pkg::K_HOSTS: begin
          if ((b & ~c) != '0) bad = 1'b1;
          else begin
            case (s_q.phase)
              rwlt_pkg::ST_PENDING, rwlt_pkg::ST_INCOMPLETE, rwlt_pkg::ST_WRITTEN: begin
                n.desired = (s_q.desired | a) & ~b; n.disabled = c;
              end
              rwlt_pkg::ST_FLUSHING: begin
                dropped = s_q.freq & ~s_q.fok & c;
                n.desired = (s_q.desired | a) & ~b; n.disabled = c;
                n.freq = s_q.freq & ~c;
                if ((n.desired & ~n.disabled & ~n.freq) != '0)
                  qact = qact | rwlt_pkg::QReqFlush;
                fin = dropped;
              end
              rwlt_pkg::ST_FLUSHED, rwlt_pkg::ST_DISCARDED: begin
                n.disabled = c; do_set = 1'b1;
              end
              default: ;
            endcase
          end
        end
        rwlt_pkg::K_LOCK: begin
          if (!(s_q.phase == rwlt_pkg::ST_WRITTEN || s_q.phase == rwlt_pkg::ST_FLUSHING ||
                s_q.phase == rwlt_pkg::ST_FLUSHED) || s_q.ereq != '0 || (&s_q.lock))
            bad = 1'b1;
          else begin
            n.lock = s_q.lock + rwlt_pkg::LockWidth'(1);
            if (s_q.lock == '0) begin
              qact = qact | rwlt_pkg::QUnregErase; bact = bact | rwlt_pkg::BLockAdd;
              bhosts = s_q.wreq;
            end
          end
        end
        rwlt_pkg::K_UNLOCK: begin
          if (!(s_q.phase == rwlt_pkg::ST_WRITTEN || s_q.phase == rwlt_pkg::ST_FLUSHING ||
                s_q.phase == rwlt_pkg::ST_FLUSHED) || s_q.lock == '0) bad = 1'b1;
          else begin
            n.lock = s_q.lock - rwlt_pkg::LockWidth'(1);
            if (n.lock == '0) begin
              bact = bact | rwlt_pkg::BLockRel; bhosts = s_q.wreq;
              do_set = 1'b1;
            end
          end
        end
        rwlt_pkg::K_QUERY: ;
        default: bad = 1'b1;
      endcase
    end

    // Flush completion check shared by flush ok and host update in flushing.
    if (!bad && s_q.phase == rwlt_pkg::ST_FLUSHING &&
        (req_i.kind == rwlt_pkg::K_FL_OK || req_i.kind == rwlt_pkg::K_HOSTS)) begin
      live = ~n.disabled;
      if ((n.desired & live) == (n.fok & live) &&
          32'(rwlt_pkg::popc(n.fok)) >= 32'(quorum_i)) begin
        n.phase = rwlt_pkg::ST_FLUSHED;
        if (!inv_ok(n, quorum_i)) bad = 1'b1;
        qact = qact | rwlt_pkg::QFlushed;
        if (n.lock == '0 && (n.wreq & ~n.disabled & ~n.ereq) != '0)
          qact = qact | rwlt_pkg::QRegErase;
      end
    end

    // Erase attempt for belated, host update and unlock; erase notice for belated and unlock.
    if (!bad && do_set) begin
      if (n.lock == '0 && can_erase(n) && can_forget(n)) begin
        n.phase = rwlt_pkg::ST_ERASED;
        if (!inv_ok(n, quorum_i)) bad = 1'b1;
        bact = bact | rwlt_pkg::BTotalRel; bhosts = n.wreq;
      end
      if (req_i.kind != rwlt_pkg::K_HOSTS && n.lock == '0 && can_erase(n) &&
          (n.wreq & ~n.disabled & ~n.ereq) != '0) qact = qact | rwlt_pkg::QRegErase;
    end
    // Host update checks the record in its final state.
    if (!bad && req_i.kind == rwlt_pkg::K_HOSTS && !inv_ok(n, quorum_i)) bad = 1'b1;

    if (bad) begin
      n = s_q; src = rwlt_pkg::SrcNone; qact = '0; bact = '0; bhosts = '0;
      fin = '0; qreached = 1'b0;
    end

    r.status   = bad;
    r.phase    = n.phase;
    r.src      = src;
    r.qact     = qact;
    r.finished = fin;
    r.bact     = bact;
    r.bhosts   = (bact != '0) ? bhosts : '0;
    r.qreached = qreached;
    case (n.phase)
      rwlt_pkg::ST_INCOMPLETE: begin r.read_hosts = '0; r.read_buf = 1'b0; end
      rwlt_pkg::ST_WRITTEN, rwlt_pkg::ST_FLUSHING: begin
        r.read_hosts = n.wok; r.read_buf = 1'b1;
      end
      default: begin r.read_hosts = '1; r.read_buf = 1'b0; end
    endcase
    r.inflight     = n.freq & ~n.fok;
    r.erase_needed = n.wreq & ~n.ereq & ~n.eok;
  end

  logic take, give;
  assign take = req_valid_i && !out_full;
  assign give = pop_i && !empty_o;
  assign s_d  = take ? n : s_q;

  always_ff @(posedge clk_i) begin
    if (take) oq_q[wp_q] <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q  <= '0;
      rp_q <= 1'b0;
      wp_q <= 1'b0;
      oc_q <= 2'd0;
    end else begin
      s_q  <= s_d;
      if (take) wp_q <= ~wp_q;
      if (give) rp_q <= ~rp_q;
      oc_q <= oc_q + 2'(take) - 2'(give);
    end
  end

endmodule

// ===== design/replica_write_lifecycle_tracker_top.sv =====
// ----------------------------------------------------------------------------
// replica_write_lifecycle_tracker_top
// Lifecycle tracker for one replicated write record with an APB quorum reg.
// ----------------------------------------------------------------------------
// One event per cycle sustained while results are popped; a request's result
// shows on the result ports once it has been registered in the front request
// queue and the record update, which waits while the result queue is full,
// has written it into the result queue. Two-entry queues on each side set the buffering.
module replica_write_lifecycle_tracker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [0:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  input  logic       push,
  output logic       full,
  input  logic [3:0] kind_i,
  input  logic [2:0] host_i,
  input  logic [7:0] mask_a_i,
  input  logic [7:0] mask_b_i,
  input  logic [7:0] mask_c_i,
  output logic       empty,
  input  logic       pop,
  output logic       status_o,
  output logic [2:0] record_state_o,
  output logic [3:0] flush_source_o,
  output logic [4:0] queue_actions_o,
  output logic [7:0] flush_finished_hosts_o,
  output logic [3:0] byte_actions_o,
  output logic [7:0] byte_hosts_o,
  output logic       quorum_reached_o,
  output logic [7:0] read_hosts_o,
  output logic       read_from_buffer_o,
  output logic [7:0] inflight_flushes_o,
  output logic [7:0] erase_needed_o
);

  logic [3:0]     quorum_q;
  logic           rv, take;
  rwlt_pkg::req_t rq;
  rwlt_pkg::res_t rs;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {28'd0, quorum_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quorum_q <= 4'd3;
    else if (psel && penable && pwrite && paddr == 1'b0) quorum_q <= pwdata[3:0];
  end

  rwlt_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .kind_i, .host_i,
    .mask_a_i, .mask_b_i, .mask_c_i, .req_valid_o(rv), .req_o(rq),
    .req_take_i(take)
  );

  rwlt_back u_back (
    .clk_i, .rst_ni, .quorum_i(quorum_q), .req_valid_i(rv), .req_i(rq),
    .req_take_o(take), .empty_o(empty), .pop_i(pop), .res_o(rs)
  );

  assign status_o               = rs.status;
  assign record_state_o         = rs.phase;
  assign flush_source_o         = rs.src;
  assign queue_actions_o        = rs.qact;
  assign flush_finished_hosts_o = 8'(rs.finished);
  assign byte_actions_o         = rs.bact;
  assign byte_hosts_o           = 8'(rs.bhosts);
  assign quorum_reached_o       = rs.qreached;
  assign read_hosts_o           = 8'(rs.read_hosts);
  assign read_from_buffer_o     = rs.read_buf;
  assign inflight_flushes_o     = 8'(rs.inflight);
  assign erase_needed_o         = 8'(rs.erase_needed);

endmodule

// ===== design/rwlt_checker.sv =====
// ----------------------------------------------------------------------------
// rwlt_checker
// Port-level checks on the tracker's result channel.
// ----------------------------------------------------------------------------
module rwlt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       status_o,
  input logic [2:0] record_state_o,
  input logic [3:0] flush_source_o,
  input logic [4:0] queue_actions_o,
  input logic [3:0] byte_actions_o,
  input logic [7:0] byte_hosts_o,
  input logic       read_from_buffer_o
);

  // Rejected results carry no actions.
  a_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o |-> queue_actions_o == '0 && byte_actions_o == '0 &&
    flush_source_o == rwlt_pkg::SrcNone)
    else $error("rejected result carries actions");

  a_bh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && byte_actions_o == '0 |-> byte_hosts_o == '0)
    else $error("byte hosts without action");

  a_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && read_from_buffer_o |->
      (record_state_o == rwlt_pkg::ST_WRITTEN || record_state_o == rwlt_pkg::ST_FLUSHING))
    else $error("buffer read outside written or flushing");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(record_state_o))
    else $error("waiting result changed");

endmodule

bind replica_write_lifecycle_tracker_top rwlt_checker u_rwlt_checker (.*);

// ===== tb/sv/replica_write_lifecycle_tracker_top_tb.sv =====
// ----------------------------------------------------------------------------
// replica_write_lifecycle_tracker_top_tb
// Self-checking bench for the replica write lifecycle tracker. A state-aware
// generator builds mostly well-formed record lifecycles (start, write, restore,
// flush, lock, erase, belated answers) mixed with noise, predicts every result
// as the request is queued, and the monitor checks each popped result field by
// field. The quorum register is rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
module replica_write_lifecycle_tracker_top_tb;
  import rwlt_pkg::*;

  typedef struct {
    kind_e      kind;
    logic [2:0] host;
    hmask_t     a;
    hmask_t     b;
    hmask_t     c;
  } event_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [0:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        push, full, empty, pop;
  logic [3:0]  kind_i;
  logic [2:0]  host_i;
  logic [7:0]  mask_a_i, mask_b_i, mask_c_i;
  logic        status_o, quorum_reached_o, read_from_buffer_o;
  logic [2:0]  record_state_o;
  logic [3:0]  flush_source_o, byte_actions_o;
  logic [4:0]  queue_actions_o;
  logic [7:0]  flush_finished_hosts_o, byte_hosts_o, read_hosts_o;
  logic [7:0]  inflight_flushes_o, erase_needed_o;

  replica_write_lifecycle_tracker_top i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .kind_i, .host_i, .mask_a_i, .mask_b_i, .mask_c_i,
    .empty, .pop, .status_o, .record_state_o, .flush_source_o, .queue_actions_o,
    .flush_finished_hosts_o, .byte_actions_o, .byte_hosts_o, .quorum_reached_o,
    .read_hosts_o, .read_from_buffer_o, .inflight_flushes_o, .erase_needed_o
  );

  // Record model state and per-event notices.
  rec_t       rec;
  logic [3:0] quorum;
  logic       rejected;
  logic [4:0] q_note;
  logic [3:0] b_note;
  hmask_t     b_hosts, done_hosts;
  logic       reached;

  event_t pending_reqs[$];
  res_t   expected_results[$];
  int     errors = 0;
  int     results_seen = 0;
  int     rejects_seen = 0;
  int     events_queued = 0;
  logic [7:0] states_seen = '0;

  function automatic void need(input logic ok);
    if (!ok) rejected = 1'b1;
  endfunction

  function automatic logic [3:0] first_host(input hmask_t m);
    for (int i = 0; i < Hosts; i++) if (m[i]) return 4'(i);
    return SrcNone;
  endfunction

  function automatic logic erasable();
    return rec.phase == ST_FLUSHED || rec.phase == ST_DISCARDED;
  endfunction

  function automatic logic forgettable();
    hmask_t ans;
    ans = rec.wans | rec.disabled;
    return (rec.wreq & ~ans) == '0 && (rec.wreq & ~rec.disabled & ~rec.eok) == '0;
  endfunction

  function automatic void check_record();
    hmask_t infl;
    infl = rec.freq & ~rec.fok;
    need((rec.wok & ~rec.wreq) == '0);
    need((rec.wans & ~rec.wreq) == '0);
    need((rec.fok & ~rec.disabled & ~rec.freq) == '0);
    need((rec.freq & ~rec.disabled & ~rec.desired) == '0);
    need((rec.eok & ~rec.ereq) == '0);
    need((rec.ereq & ~rec.wreq) == '0);
    need((rec.eearly & ~rec.ereq) == '0);
    need((rec.eearly & rec.eok) == '0);
    case (rec.phase)
      ST_PENDING: begin
        need(rec.wreq == '0 && rec.wok == '0 && rec.freq == '0 && rec.fok == '0);
        need(rec.ereq == '0 && rec.eok == '0);
      end
      ST_INCOMPLETE: begin
        need(rec.freq == '0 && rec.fok == '0 && rec.ereq == '0 && rec.eok == '0);
        need($countones(rec.wok) < quorum);
      end
      ST_WRITTEN: begin
        need($countones(rec.wok) >= quorum);
        need(rec.freq == '0 && rec.fok == '0 && rec.ereq == '0 && rec.eok == '0);
      end
      ST_FLUSHING: begin
        need($countones(rec.wok) >= quorum);
        need(rec.ereq == '0 && rec.eok == '0);
      end
      ST_FLUSHED: need($countones(rec.fok) >= quorum && infl == '0);
      ST_DISCARDED: need(infl == '0 && rec.lock == '0);
      default: need(infl == '0 && forgettable() && rec.lock == '0);
    endcase
  endfunction

  function automatic void move_to(input phase_e ns);
    phase_e p;
    logic ok;
    p = rec.phase;
    if (p == ns) return;
    case (ns)
      ST_INCOMPLETE: ok = p == ST_PENDING;
      ST_WRITTEN:    ok = p == ST_PENDING || p == ST_INCOMPLETE;
      ST_FLUSHING:   ok = p == ST_WRITTEN;
      ST_FLUSHED:    ok = p == ST_FLUSHING;
      ST_DISCARDED:  ok = p == ST_PENDING;
      ST_ERASED:     ok = p == ST_FLUSHED || p == ST_DISCARDED;
      default:       ok = 1'b0;
    endcase
    if (!ok) begin
      rejected = 1'b1;
      return;
    end
    rec.phase = ns;
    check_record();
    if (ns == ST_FLUSHED) q_note |= QFlushed;
    if (ns == ST_ERASED) begin
      b_note |= BTotalRel;
      b_hosts = rec.wreq;
    end
  endfunction

  function automatic void ask_erase();
    if (rec.lock != '0 || !erasable()) return;
    if ((rec.wreq & ~rec.disabled & ~rec.ereq) != '0) q_note |= QRegErase;
  endfunction

  function automatic void try_erased();
    if (rec.lock != '0 || !erasable()) return;
    if (forgettable()) move_to(ST_ERASED);
  endfunction

  function automatic void try_flushed();
    need(rec.phase == ST_FLUSHING);
    if ((rec.desired & ~rec.disabled) == (rec.fok & ~rec.disabled) &&
        $countones(rec.fok) >= quorum) begin
      move_to(ST_FLUSHED);
      ask_erase();
    end
  endfunction

  function automatic void retry_erase(input hmask_t hb);
    rec.eearly &= ~hb;
    rec.ereq &= ~hb;
    ask_erase();
  endfunction

  function automatic res_t predict_event(input event_t ev);
    rec_t saved;
    res_t r;
    hmask_t hb, ans, done, infl, dropped;
    logic [3:0] src, cand;
    phase_e p;
    saved = rec;
    p = rec.phase;
    hb = hmask_t'(1) << ev.host;
    src = SrcNone;
    rejected = 1'b0;
    q_note = '0;
    b_note = '0;
    b_hosts = '0;
    done_hosts = '0;
    reached = 1'b0;
    case (ev.kind)
      K_START: begin
        rec = '0;
        rec.phase = ST_PENDING;
        rec.desired = ev.a;
        rec.disabled = ev.b;
      end
      K_RESTORE: begin
        need(p == ST_PENDING || p == ST_INCOMPLETE || p == ST_WRITTEN);
        need((rec.wreq & hb) == '0 && (rec.wok & hb) == '0);
        if (!rejected) begin
          rec.wreq |= hb;
          rec.wok |= hb;
          rec.wans |= hb;
          b_note |= BTotalAdd;
          b_hosts = hb;
          if ($countones(rec.wok) >= quorum) begin
            if (p != ST_WRITTEN) reached = 1'b1;
            move_to(ST_WRITTEN);
            q_note |= QReqFlush;
          end else begin
            move_to(ST_INCOMPLETE);
            q_note |= QRegClone;
          end
        end
      end
      K_WRITE: begin
        need(p == ST_PENDING && rec.wok == '0);
        if (!rejected) begin
          rec.wreq = ev.a;
          rec.wok = ev.b;
          rec.wans = ev.c;
          b_note |= BTotalAdd;
          b_hosts = ev.a;
          if ($countones(ev.b) >= quorum) begin
            move_to(ST_WRITTEN);
            q_note |= QReqFlush;
            reached = 1'b1;
          end else begin
            move_to(ST_DISCARDED);
            try_erased();
            ask_erase();
          end
        end
      end
      K_BELATED: begin
        ans = ev.a | ev.b;
        need((ev.a & ev.b) == '0);
        need((ans & ~rec.wreq) == '0);
        need(p != ST_ERASED);
        if (!rejected) begin
          rec.wok |= ev.a;
          rec.wans |= ans;
          done = ans & rec.eok;
          infl = ans & rec.ereq & ~rec.eok;
          rec.eearly |= infl;
          rec.ereq &= ~done;
          rec.eok &= ~done;
          try_erased();
          ask_erase();
        end
      end
      K_FL_REQ: begin
        need(p == ST_WRITTEN || p == ST_FLUSHING);
        if (!rejected && (rec.desired & ~rec.disabled & hb) != '0 &&
            (rec.freq & hb) == '0) begin
          if ((rec.wok & hb) != '0) cand = 4'(ev.host);
          else begin
            cand = first_host(rec.wok & ~rec.disabled);
            if (cand == SrcNone) cand = first_host(rec.wok);
          end
          if (cand == SrcNone) rejected = 1'b1;
          else begin
            move_to(ST_FLUSHING);
            rec.freq |= hb;
            src = cand;
          end
        end
      end
      K_FL_OK, K_FL_FAIL: begin
        need(p == ST_FLUSHING);
        need((rec.freq & hb) != '0 && (rec.fok & hb) == '0);
        if (!rejected) begin
          done_hosts |= hb;
          if (ev.kind == K_FL_OK) begin
            rec.fok |= hb;
            try_flushed();
          end else begin
            rec.freq &= ~hb;
            q_note |= QReqFlush;
          end
        end
      end
      K_ER_REQ: begin
        need(erasable() && (rec.wreq & hb) != '0);
        need((rec.ereq & hb) == '0 && (rec.eok & hb) == '0);
        need(rec.lock == '0);
        if (!rejected) rec.ereq |= hb;
      end
      K_ER_OK: begin
        need(erasable() && (rec.ereq & hb) != '0);
        need((rec.eok & hb) == '0 && rec.lock == '0);
        if (!rejected) begin
          if ((rec.eearly & hb) != '0) retry_erase(hb);
          else begin
            rec.eok |= hb;
            try_erased();
          end
        end
      end
      K_ER_FAIL: begin
        need(erasable() || p == ST_ERASED);
        need((rec.eok & hb) == '0 && rec.lock == '0);
        if (!rejected) begin
          if (p == ST_ERASED) need((rec.disabled & hb) != '0);
          else retry_erase(hb);
        end
      end
      K_HOSTS: begin
        need((ev.b & ~ev.c) == '0);
        if (!rejected) begin
          if (p <= ST_WRITTEN) begin
            rec.desired = (rec.desired | ev.a) & ~ev.b;
            rec.disabled = ev.c;
          end else if (p == ST_FLUSHING) begin
            dropped = rec.freq & ~rec.fok & ev.c;
            rec.desired = (rec.desired | ev.a) & ~ev.b;
            rec.disabled = ev.c;
            rec.freq &= ~ev.c;
            if ((rec.desired & ~rec.disabled & ~rec.freq) != '0) q_note |= QReqFlush;
            done_hosts |= dropped;
            try_flushed();
          end else if (p == ST_FLUSHED || p == ST_DISCARDED) begin
            rec.disabled = ev.c;
            try_erased();
          end
          check_record();
        end
      end
      K_LOCK: begin
        need(p == ST_WRITTEN || p == ST_FLUSHING || p == ST_FLUSHED);
        need(rec.ereq == '0 && rec.lock != '1);
        if (!rejected) begin
          rec.lock++;
          if (rec.lock == lock_t'(1)) begin
            q_note |= QUnregErase;
            b_note |= BLockAdd;
            b_hosts = rec.wreq;
          end
        end
      end
      K_UNLOCK: begin
        need(p == ST_WRITTEN || p == ST_FLUSHING || p == ST_FLUSHED);
        need(rec.lock != '0);
        if (!rejected) begin
          rec.lock--;
          if (rec.lock == '0) begin
            b_note |= BLockRel;
            b_hosts = rec.wreq;
            try_erased();
            ask_erase();
          end
        end
      end
      K_QUERY: ;
      default: rejected = 1'b1;
    endcase
    if (rejected) begin
      rec = saved;
      src = SrcNone;
      q_note = '0;
      b_note = '0;
      b_hosts = '0;
      done_hosts = '0;
      reached = 1'b0;
    end
    r.status = rejected;
    r.phase = rec.phase;
    r.src = src;
    r.qact = q_note;
    r.finished = done_hosts;
    r.bact = b_note;
    r.bhosts = (b_note != '0) ? b_hosts : '0;
    r.qreached = reached;
    if (rec.phase == ST_INCOMPLETE) begin
      r.read_hosts = '0;
      r.read_buf = 1'b0;
    end else if (rec.phase == ST_WRITTEN || rec.phase == ST_FLUSHING) begin
      r.read_hosts = rec.wok;
      r.read_buf = 1'b1;
    end else begin
      r.read_hosts = '1;
      r.read_buf = 1'b0;
    end
    r.inflight = rec.freq & ~rec.fok;
    r.erase_needed = rec.wreq & ~rec.ereq & ~rec.eok;
    return r;
  endfunction

  task automatic queue_event(input kind_e k, input int h, input hmask_t a,
                             input hmask_t b, input hmask_t c);
    event_t ev;
    ev.kind = k;
    ev.host = 3'(h);
    ev.a = a;
    ev.b = b;
    ev.c = c;
    expected_results.push_back(predict_event(ev));
    pending_reqs.push_back(ev);
    events_queued++;
  endtask

  // Random host out of a mask, any host when the mask is empty.
  function automatic int pick_host(input hmask_t m);
    int h;
    if (m == '0) return $urandom_range(0, Hosts - 1);
    do h = $urandom_range(0, Hosts - 1); while (!m[h]);
    return h;
  endfunction

  task automatic queue_random_event();
    int r, x;
    hmask_t a, b, c, open;
    r = $urandom_range(0, 99);
    x = $urandom_range(0, 9);
    a = hmask_t'($urandom);
    b = hmask_t'($urandom);
    c = hmask_t'($urandom);
    if (r < 6) begin
      queue_event(K_START, 0, x < 5 ? 8'hFF : a, x < 7 ? 8'h00 : b & c, c);
    end else if (r < 16) begin
      queue_event(kind_e'($urandom_range(0, 15)), $urandom_range(0, 7), a, b, c);
    end else if (r < 22) begin
      queue_event(x < 8 ? K_HOSTS : K_QUERY, 0, a & hmask_t'($urandom), c & b,
                  c & hmask_t'($urandom));
    end else begin
      case (rec.phase)
        ST_PENDING: begin
          if (x < 6) queue_event(K_WRITE, 0, a, a & b, (a & c) | (a & b));
          else queue_event(K_RESTORE, pick_host(~rec.wreq), a, b, c);
        end
        ST_INCOMPLETE: queue_event(K_RESTORE, pick_host(~rec.wreq), a, b, c);
        ST_WRITTEN, ST_FLUSHING: begin
          if (x < 4) queue_event(K_FL_REQ, pick_host(rec.desired & ~rec.disabled & ~rec.freq),
                                 a, b, c);
          else if (x < 6) queue_event(K_FL_OK, pick_host(rec.freq & ~rec.fok), a, b, c);
          else if (x < 7) queue_event(K_FL_FAIL, pick_host(rec.freq & ~rec.fok), a, b, c);
          else if (x < 8) queue_event(K_LOCK, 0, a, b, c);
          else if (x < 9) queue_event(K_UNLOCK, 0, a, b, c);
          else if (rec.phase == ST_WRITTEN)
            queue_event(K_RESTORE, pick_host(~rec.wreq), a, b, c);
          else begin
            open = rec.wreq & ~rec.wans;
            queue_event(K_BELATED, 0, open & a, open & ~a & b, c);
          end
        end
        default: begin
          open = rec.wreq & ~rec.wans;
          if (x < 3) queue_event(K_ER_REQ, pick_host(rec.wreq & ~rec.ereq & ~rec.eok), a, b, c);
          else if (x < 5) queue_event(K_ER_OK, pick_host(rec.ereq & ~rec.eok), a, b, c);
          else if (x < 6) queue_event(K_ER_FAIL, pick_host(rec.ereq), a, b, c);
          else if (x < 8) queue_event(K_BELATED, 0, open & a, open & ~a & b, c);
          else if (x < 9) queue_event(K_UNLOCK, 0, a, b, c);
          else queue_event(K_LOCK, 0, a, b, c);
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_quorum(input int value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    quorum = 4'(value);
  endtask

  task automatic chk(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("result %0d: %s expected %0h got %0h", results_seen, field, want, got);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Driver: bursts of requests separated by random gaps.
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    event_t ev;
    if (!rst_ni) begin
      push <= 1'b0;
      kind_i <= '0;
      host_i <= '0;
      mask_a_i <= '0;
      mask_b_i <= '0;
      mask_c_i <= '0;
      burst_left = 0;
      gap_left = 0;
    end else if (!push || !full) begin
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        ev = pending_reqs.pop_front();
        kind_i <= ev.kind;
        host_i <= ev.host;
        mask_a_i <= ev.a;
        mask_b_i <= ev.b;
        mask_c_i <= ev.c;
        push <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: pop on a stall pattern that is redrawn whenever the stall counter wraps.
  int stall_pct, stall_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
      stall_pct = 0;
      stall_cnt = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          chk("status", want.status, status_o);
          chk("record_state", want.phase, record_state_o);
          chk("flush_source", want.src, flush_source_o);
          chk("queue_actions", want.qact, queue_actions_o);
          chk("flush_finished_hosts", want.finished, flush_finished_hosts_o);
          chk("byte_actions", want.bact, byte_actions_o);
          chk("byte_hosts", want.bhosts, byte_hosts_o);
          chk("quorum_reached", want.qreached, quorum_reached_o);
          chk("read_hosts", want.read_hosts, read_hosts_o);
          chk("read_from_buffer", want.read_buf, read_from_buffer_o);
          chk("inflight_flushes", want.inflight, inflight_flushes_o);
          chk("erase_needed", want.erase_needed, erase_needed_o);
          if (want.status) rejects_seen++;
          states_seen[want.phase] = 1'b1;
        end
        results_seen++;
      end
      if (++stall_cnt == 64) begin
        stall_cnt = 0;
        case ($urandom_range(0, 3))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      pop <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  initial begin
    int settings[4];
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rec = '0;
    rec.phase = ST_PENDING;
    quorum = 4'd3;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk at the reset quorum of three.
    queue_event(K_QUERY, 0, 8'h00, 8'h00, 8'h00);
    queue_event(K_START, 0, 8'hFF, 8'h00, 8'h00);
    queue_event(K_RESTORE, 0, 8'h00, 8'h00, 8'h00);
    queue_event(K_RESTORE, 1, 8'h00, 8'h00, 8'h00);
    queue_event(K_RESTORE, 1, 8'h00, 8'h00, 8'h00);
    queue_event(K_RESTORE, 7, 8'h00, 8'h00, 8'h00);
    queue_event(K_FL_REQ, 5, 8'h00, 8'h00, 8'h00);
    queue_event(K_FL_REQ, 5, 8'h00, 8'h00, 8'h00);
    queue_event(K_FL_REQ, 0, 8'h00, 8'h00, 8'h00);
    queue_event(K_LOCK, 0, 8'h00, 8'h00, 8'h00);
    queue_event(K_UNLOCK, 0, 8'h00, 8'h00, 8'h00);
    queue_event(K_FL_FAIL, 5, 8'h00, 8'h00, 8'h00);
    queue_event(K_HOSTS, 0, 8'h00, 8'hFE, 8'hFE);
    queue_event(K_FL_OK, 0, 8'h00, 8'h00, 8'h00);
    queue_event(K_BAD14, 0, 8'hFF, 8'hFF, 8'hFF);
    queue_event(K_BAD15, 7, 8'hFF, 8'hFF, 8'hFF);
    queue_event(K_START, 0, 8'hFF, 8'hFF, 8'hFF);
    queue_event(K_WRITE, 0, 8'hFF, 8'h01, 8'h03);
    queue_event(K_ER_REQ, 0, 8'h00, 8'h00, 8'h00);
    queue_event(K_BELATED, 0, 8'h04, 8'h08, 8'h00);
    queue_event(K_BELATED, 0, 8'h10, 8'h10, 8'h00);
    queue_event(K_ER_OK, 0, 8'h00, 8'h00, 8'h00);
    queue_event(K_ER_FAIL, 1, 8'h00, 8'h00, 8'h00);
    queue_event(K_HOSTS, 0, 8'h00, 8'h00, 8'hFF);
    queue_event(K_ER_FAIL, 2, 8'h00, 8'h00, 8'h00);

    settings[0] = 1;
    settings[1] = 8;
    settings[2] = $urandom_range(1, 8);
    settings[3] = 2;
    foreach (settings[i]) begin
      wait_idle();
      write_quorum(settings[i]);
      queue_event(K_START, 0, 8'hFF, 8'h00, 8'h00);
      repeat (425) queue_random_event();
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("checked %0d results of %0d requests, %0d rejected", results_seen,
             events_queued, rejects_seen);
    $display("record states reached (bit per state): %b, quorum settings 1..8 used",
             states_seen);
    if (errors == 0) $display("replica_write_lifecycle_tracker_top: match");
    else $display("replica_write_lifecycle_tracker_top: mismatch");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("replica_write_lifecycle_tracker_top: mismatch");
    $finish;
  end

endmodule
